### hw/rtl/bdy_pkg.sv
// bdy_pkg: shared constants for the buddy allocator
// status codes, operation codes and the heap base reset value
// no dependencies

package bdy_pkg;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  // heap base after reset
  localparam logic [31:0] HEAP_BASE_RST = 32'h2000_1000;

endpackage

### hw/rtl/bdy_table.sv
// bdy_table: single-port control word memory with registered read
// no dependencies

module bdy_table #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/buddy_allocator.sv
// Buddy allocator over a heap of HEAP_BYTES bytes split into ENTRIES units of
// MIN_BLOCK bytes, one control word per unit held in a single-port memory with
// a registered read. After reset a clearing pass initializes the table; no item
// is taken during it. An allocate scans the candidate blocks at the target size
// (up to ENTRIES for the smallest size) and then climbs the tree levels above
// it. A free reads the block and then tries a buddy merge at each level, and an
// out-of-range free ends at the range check. The sequencing is set by the one
// memory port, which serves a single read or write each cycle. One item is in
// work at a time; the result register lets the next item in while a result
// still waits for its transfer.
// depends on bdy_pkg and bdy_table

module buddy_allocator #(
  parameter int HEAP_BYTES = 16384,
  parameter int MIN_BLOCK  = 32,
  parameter int ENTRIES    = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [14:0] in_alloc_size,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_address,
  output logic [1:0]  out_status
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LOGMIN = $clog2(MIN_BLOCK);
  localparam int MAXB   = (HEAP_BYTES > ENTRIES * MIN_BLOCK) ? HEAP_BYTES
                                                             : ENTRIES * MIN_BLOCK;
  localparam int WORD_W = $clog2(MAXB) + 1;
  localparam int LVL_W  = $clog2(IDX_W + 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_LVL, S_A_SCAN, S_A_LEAF, S_A_UP, S_A_UPCHK,
    S_F_CHK, S_F_RD0, S_F_STEP, S_F_BCHK, S_F_W2, S_DONE
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [31:0]       heap_base_r;
  logic [14:0]       size_r;
  logic [31:0]       addr_r;
  logic [LVL_W-1:0]  lg_r;
  logic [LVL_W-1:0]  j_r;
  logic [IDX_W:0]    scan_idx_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              pend_r;
  logic [IDX_W-1:0]  found_r;
  logic [IDX_W-1:0]  mid_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  b_r;
  logic              odd_r;
  logic [WORD_W-1:0] bsize_r;
  logic [31:0]       res_addr_r;
  logic [1:0]        status_r;
  logic              out_valid_r;
  logic [31:0]       out_addr_r;
  logic [1:0]        out_status_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  bdy_table #(.DEPTH(ENTRIES), .WIDTH(WORD_W)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= bdy_pkg::HEAP_BASE_RST;
    end else if (cfg_we) begin
      heap_base_r <= cfg_wdata;
    end
  end

  // target tree level for an allocate: descend while the request fits a half
  logic [LVL_W-1:0] lg_calc;
  always_comb begin
    lg_calc = LVL_W'(IDX_W);
    for (int j = IDX_W; j >= 1; j--) begin
      if ({17'b0, size_r} <= 32'(MIN_BLOCK << (j - 1))) begin
        lg_calc = LVL_W'(j - 1);
      end
    end
  end

  // scan and climb helpers
  logic [WORD_W-1:0] whole;
  logic              hit;
  logic [IDX_W:0]    stride;
  logic [IDX_W:0]    found_ext;
  logic [IDX_W:0]    found_sh;
  logic [IDX_W-1:0]  mid_calc;
  logic [WORD_W-1:0] half;
  assign whole     = WORD_W'(MIN_BLOCK) << lg_r;
  assign hit       = !mem_rdata[0] && (mem_rdata >= whole);
  assign stride    = (IDX_W+1)'(1) << lg_r;
  assign found_ext = {1'b0, found_r};
  assign found_sh  = found_ext >> (j_r - LVL_W'(1));
  assign mid_calc  = IDX_W'(((found_ext >> j_r) << j_r) |
                            ((IDX_W+1)'(1) << (j_r - LVL_W'(1))));
  assign half      = WORD_W'(MIN_BLOCK) << (j_r - LVL_W'(1));

  // free helpers
  logic [31:0]       off;
  logic              range_bad;
  logic [IDX_W-1:0]  cur_calc;
  logic [WORD_W-1:0] bs0;
  logic [WORD_W-1:0] rd_masked;
  logic [WORD_W:0]   bud_d;
  logic [WORD_W:0]   cur_w;
  logic [WORD_W:0]   up_sum;
  logic              odd_calc;
  logic              top_reached;
  logic [IDX_W-1:0]  b_calc;
  logic              merge_ok;
  assign off       = addr_r - heap_base_r;
  assign range_bad = (addr_r < heap_base_r) || (off > 32'(HEAP_BYTES - MIN_BLOCK)) ||
                     ((off >> LOGMIN) >= 32'(ENTRIES));
  assign cur_calc  = IDX_W'(off >> LOGMIN);
  assign bs0       = mem_rdata & ~WORD_W'(MIN_BLOCK - 1);
  assign rd_masked = mem_rdata & ~WORD_W'(MIN_BLOCK - 1);
  assign bud_d     = (WORD_W+1)'(bsize_r >> LOGMIN);
  assign cur_w     = (WORD_W+1)'(cur_r);
  assign up_sum    = cur_w + bud_d;
  assign odd_calc  = |(cur_w & bud_d);
  assign top_reached = !odd_calc && ((bud_d >= (WORD_W+1)'(ENTRIES)) ||
                                     (up_sum >= (WORD_W+1)'(ENTRIES)));
  assign b_calc    = odd_calc ? IDX_W'(cur_w - bud_d) : IDX_W'(up_sum);
  assign merge_ok  = !mem_rdata[0] && (rd_masked == bsize_r);

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx_r;
        mem_wdata = (clr_idx_r == '0) ? WORD_W'(HEAP_BYTES) : '0;
      end
      S_A_SCAN: begin
        mem_addr = scan_idx_r[IDX_W-1:0];
      end
      S_A_LEAF: begin
        mem_we    = 1'b1;
        mem_addr  = found_r;
        mem_wdata = whole | WORD_W'(1);
      end
      S_A_UP: begin
        mem_addr = mid_calc;
      end
      S_A_UPCHK: begin
        mem_we    = !mem_rdata[0];
        mem_addr  = mid_r;
        mem_wdata = half;
      end
      S_F_CHK: begin
        mem_addr = cur_calc;
      end
      S_F_RD0: begin
        mem_we    = (bs0 != '0);
        mem_addr  = cur_r;
        mem_wdata = bs0;
      end
      S_F_STEP: begin
        mem_addr = b_calc;
      end
      S_F_BCHK: begin
        mem_we   = merge_ok;
        mem_addr = odd_r ? cur_r : b_r;
      end
      S_F_W2: begin
        mem_we    = 1'b1;
        mem_addr  = cur_r;
        mem_wdata = bsize_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (&clr_idx_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            size_r <= in_alloc_size;
            addr_r <= in_block_address;
            if (in_op == bdy_pkg::OP_FREE) begin
              state_r <= S_F_CHK;
            end else if ({17'b0, in_alloc_size} > 32'(HEAP_BYTES)) begin
              res_addr_r <= '0;
              status_r   <= bdy_pkg::ST_NOSPACE;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_A_LVL;
            end
          end
        end
        S_A_LVL: begin
          lg_r       <= lg_calc;
          scan_idx_r <= '0;
          pend_r     <= 1'b0;
          state_r    <= S_A_SCAN;
        end
        S_A_SCAN: begin
          if (pend_r && hit) begin
            found_r <= chk_idx_r;
            pend_r  <= 1'b0;
            state_r <= S_A_LEAF;
          end else if (!scan_idx_r[IDX_W]) begin
            chk_idx_r  <= scan_idx_r[IDX_W-1:0];
            pend_r     <= 1'b1;
            scan_idx_r <= scan_idx_r + stride;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              res_addr_r <= '0;
              status_r   <= bdy_pkg::ST_NOSPACE;
              state_r    <= S_DONE;
            end
          end
        end
        S_A_LEAF: begin
          res_addr_r <= heap_base_r + (32'(found_r) << LOGMIN);
          status_r   <= bdy_pkg::ST_OK;
          j_r        <= lg_r + LVL_W'(1);
          state_r    <= S_A_UP;
        end
        S_A_UP: begin
          if (j_r > LVL_W'(IDX_W)) begin
            state_r <= S_DONE;
          end else if (!found_sh[0]) begin
            mid_r   <= mid_calc;
            state_r <= S_A_UPCHK;
          end else begin
            j_r <= j_r + LVL_W'(1);
          end
        end
        S_A_UPCHK: begin
          j_r     <= j_r + LVL_W'(1);
          state_r <= S_A_UP;
        end
        S_F_CHK: begin
          if (range_bad) begin
            res_addr_r <= '0;
            status_r   <= bdy_pkg::ST_RANGE;
            state_r    <= S_DONE;
          end else begin
            cur_r   <= cur_calc;
            state_r <= S_F_RD0;
          end
        end
        S_F_RD0: begin
          if (bs0 == '0) begin
            res_addr_r <= '0;
            status_r   <= bdy_pkg::ST_ZERO;
            state_r    <= S_DONE;
          end else begin
            bsize_r    <= bs0;
            res_addr_r <= addr_r;
            status_r   <= bdy_pkg::ST_OK;
            state_r    <= S_F_STEP;
          end
        end
        S_F_STEP: begin
          if (top_reached) begin
            state_r <= S_DONE;
          end else begin
            b_r     <= b_calc;
            odd_r   <= odd_calc;
            state_r <= S_F_BCHK;
          end
        end
        S_F_BCHK: begin
          if (!merge_ok) begin
            state_r <= S_DONE;
          end else begin
            bsize_r <= bsize_r << 1;
            if (odd_r) begin
              cur_r <= b_r;
            end
            state_r <= S_F_W2;
          end
        end
        S_F_W2: begin
          state_r <= S_F_STEP;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= res_addr_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

endmodule

### verif/buddy_allocator_tb.sv
// buddy_allocator_tb: self-checking bench for the buddy allocator
// predicts allocate/free results from its own copy of the control table
// depends on bdy_pkg and buddy_allocator
`timescale 1ns / 100ps

module buddy_allocator_tb;

  localparam int HEAP = 16384;
  localparam int UNIT = 32;
  localparam int NUNITS = 512;

  // expected results and the allocator state that produces them
  class heap_scoreboard;
    logic [31:0] base;
    logic [15:0] ctl [NUNITS];
    logic [31:0] exp_addr [$];
    logic [1:0]  exp_status [$];
    int          errors;

    function new();
      base = bdy_pkg::HEAP_BASE_RST;
      foreach (ctl[i]) ctl[i] = '0;
      ctl[0] = 16'(HEAP);
      errors = 0;
    endfunction

    function int pending();
      return exp_addr.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // depth-first search, left half first, splitting on the way back up
    function bit grab(int unsigned size, int unsigned first, int unsigned count,
                      ref logic [31:0] addr);
      int unsigned whole, halfn, half, mid;
      logic [15:0] cur;
      whole = count * UNIT;
      halfn = count / 2;
      half = halfn * UNIT;
      if (first >= NUNITS || count == 0) return 1'b0;
      if (count >= 2 && size <= half) begin
        mid = first + halfn;
        if (!grab(size, first, halfn, addr)) return grab(size, mid, halfn, addr);
        if (mid < NUNITS && ctl[mid][0] == 1'b0) ctl[mid] = 16'(half);
        return 1'b1;
      end
      cur = ctl[first];
      if (cur[0] || cur < whole) return 1'b0;
      ctl[first] = 16'(whole) | 16'd1;
      addr = base + first * UNIT;
      return 1'b1;
    endfunction

    // accepted input: work out the result and queue it
    function void note(logic op, logic [14:0] size, logic [31:0] addr,
                       output logic [31:0] raddr, output logic [1:0] st);
      logic [31:0] off, bud;
      int unsigned cur, bsize, d, b;
      raddr = '0;
      if (op == bdy_pkg::OP_ALLOC) begin
        if (size <= HEAP && grab(size, 0, NUNITS, raddr)) st = bdy_pkg::ST_OK;
        else begin
          raddr = '0;
          st = bdy_pkg::ST_NOSPACE;
        end
      end else begin
        off = addr - base;
        if (addr < base || off > HEAP - UNIT) st = bdy_pkg::ST_RANGE;
        else begin
          cur = off / UNIT;
          bsize = ctl[cur] & ~(UNIT - 1);
          if (bsize == 0) st = bdy_pkg::ST_ZERO;
          else begin
            ctl[cur] = 16'(bsize);
            // merge with free buddies of equal size
            forever begin
              d = bsize / UNIT;
              if (((cur / d) & 1) == 0) begin
                if (d >= NUNITS || cur + d >= NUNITS) break;
                b = cur + d;
                bud = ctl[b];
                if (bud[0] || (bud & ~(UNIT - 1)) != bsize) break;
                ctl[b] = '0;
                bsize *= 2;
                ctl[cur] = 16'(bsize);
              end else begin
                b = cur - d;
                bud = ctl[b];
                if (bud[0] || (bud & ~(UNIT - 1)) != bsize) break;
                ctl[cur] = '0;
                bsize *= 2;
                ctl[b] = 16'(bsize);
                cur = b;
              end
            end
            raddr = addr;
            st = bdy_pkg::ST_OK;
          end
        end
      end
      exp_addr.push_back(raddr);
      exp_status.push_back(st);
    endfunction

    // result transfer: compare with the oldest expectation
    task check(logic [31:0] raddr, logic [1:0] st);
      logic [31:0] wa;
      logic [1:0]  ws;
      if (exp_addr.size() == 0) begin
        report("unexpected result", raddr, '0);
        return;
      end
      wa = exp_addr.pop_front();
      ws = exp_status.pop_front();
      if (raddr !== wa) report("result_address", raddr, wa);
      if (st !== ws) report("status", 32'(st), 32'(ws));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = bdy_pkg::OP_ALLOC;
  logic [14:0] in_alloc_size = '0;
  logic [31:0] in_block_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_address;
  logic [1:0]  out_status;

  heap_scoreboard sb = new();
  bit          burst = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned n_results = 0;
  int unsigned live [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  buddy_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_alloc_size     (in_alloc_size),
    .in_block_address  (in_block_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_address(out_result_address),
    .out_status        (out_status)
  );

  // offer one request and wait for its transfer
  task send(logic op, logic [14:0] size, logic [31:0] addr,
            output logic [31:0] raddr, output logic [1:0] st);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_alloc_size <= size;
    in_block_address <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note(op, size, addr, raddr, st);
  endtask

  // register write once nothing is outstanding
  task set_base(logic [31:0] value);
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    sb.base = value;
  endtask

  task do_alloc(logic [14:0] size);
    logic [31:0] ra;
    logic [1:0]  st;
    send(bdy_pkg::OP_ALLOC, size, '0, ra, st);
    if (st == bdy_pkg::ST_OK) live.push_back(ra - sb.base);
  endtask

  task do_free(logic [31:0] addr);
    logic [31:0] ra;
    logic [1:0]  st;
    send(bdy_pkg::OP_FREE, 15'($urandom()), addr, ra, st);
  endtask

  // random mix: mostly live-block traffic, some noise
  task random_phase(int n);
    int unsigned r, idx, off;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 55 || live.size() == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) do_alloc(15'($urandom_range(0, 256)));
        else if (r < 95) do_alloc(15'($urandom_range(257, 4096)));
        else do_alloc(15'($urandom_range(4097, 32767)));
      end else if (r < 90) begin
        idx = $urandom_range(0, live.size() - 1);
        off = live[idx];
        live.delete(idx);
        if ($urandom_range(0, 7) == 0) off += $urandom_range(0, UNIT - 1);
        do_free(sb.base + off);
      end else if (r < 95) begin
        do_free(sb.base + $urandom_range(0, HEAP - 1));
      end else begin
        do_free($urandom());
      end
    end
    burst = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (!hold_done && n_results == 150) begin
        hold_done = 1'b1;
        @(negedge clk) out_ready <= 1'b0;
        repeat (2000) @(negedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check(out_result_address, out_status);
      n_results++;
    end
  end

  // stimulus
  initial begin
    logic [31:0] b;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, range and zero-size errors, merges, whole heap
    b = bdy_pkg::HEAP_BASE_RST;
    do_alloc(15'd16384);
    do_alloc(15'd32);
    do_free(b + HEAP);
    do_free(b - 1);
    do_free(b + HEAP - UNIT + 31);
    do_free(b);
    do_alloc(15'd0);
    do_alloc(15'd32);
    do_alloc(15'd33);
    do_free(b + 64 + 5);
    do_free(b + 96);
    do_free(b + 32);
    do_free(b + 32);
    do_free(b);
    do_alloc(15'd16385);
    do_alloc(15'd32767);
    do_alloc(15'd8192);
    do_alloc(15'd8192);
    do_alloc(15'd1);
    do_free(b + 8192);
    do_free(b);
    do_free(32'hFFFF_FFFF);
    do_free(32'h0000_0000);
    live.delete();

    random_phase(400);
    set_base(32'h0000_0000);
    live.delete();
    do_free(32'h0000_0000);
    random_phase(380);
    set_base(32'hFFFF_C000);
    live.delete();
    random_phase(380);
    set_base(32'hFFFF_FFFF);
    live.delete();
    do_free(32'hFFFF_FFFF);
    random_phase(200);
    set_base($urandom());
    live.delete();
    random_phase(300);
    set_base(bdy_pkg::HEAP_BASE_RST);
    live.delete();
    random_phase(270);

    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS buddy_allocator");
    else $display("FAIL buddy_allocator");
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("FAIL buddy_allocator");
    $finish;
  end

endmodule

### buddy_allocator.f
hw/rtl/bdy_pkg.sv
hw/rtl/bdy_table.sv
hw/rtl/buddy_allocator.sv
verif/buddy_allocator_tb.sv
